/* hdl/tqv_pkg.sv */
// ----------------------------------------------------------------------------
// tqv_pkg
// Shared types, constants and helpers for the torus quad vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tqv_pkg;

    localparam int MAX_DIVISIONS_DEF = 1024;
    localparam int SINE_DEPTH_DEF    = 1024;   // power of two

    localparam int RADIUS_W   = 20;
    localparam int CNT_W      = 11;
    localparam int IDX_W      = 10;
    localparam int POS_W      = 24;
    localparam int NORM_W     = 16;
    localparam int TEX_W      = 17;
    localparam int ROM_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int TR_W       = RADIUS_W + 2;  // r * sin / r * cos, signed
    localparam int W_W        = RADIUS_W + 3;  // R + r * cos, signed

    localparam logic [RADIUS_W-1:0] TUBE_RESET  = RADIUS_W'(4096);
    localparam logic [RADIUS_W-1:0] RING_RESET  = RADIUS_W'(8192);
    localparam logic [CNT_W-1:0]    COUNT_RESET = CNT_W'(16);

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam logic [2:0] SEQ_LAST = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TUBE_RADIUS,
        REG_RING_RADIUS,
        REG_SLICE_COUNT,
        REG_STACK_COUNT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CORNER_ONE,
        CORNER_TWO,
        CORNER_THREE,
        CORNER_FOUR
    } corner_t;

    typedef enum logic [1:0] {
        FILL_IDLE,
        FILL_DIV,
        FILL_WALK
    } fill_state_t;

    typedef struct packed {
        logic [IDX_W-1:0] stack_index;
        logic [IDX_W-1:0] slice_index;
    } quad_t;

    typedef struct packed {
        logic [1:0]               corner;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic [TEX_W-1:0]         tex_u;
        logic [TEX_W-1:0]         tex_v;
        logic                     last;
    } vertex_t;

    typedef struct packed {
        logic [1:0] corner;
        logic       last;
    } vtag_t;

    // Two triangles: corners 1,2,4 then 2,3,4
    function automatic corner_t corner_at(input logic [2:0] step);
        corner_t c;
        case (step)
            3'd0:    c = CORNER_ONE;
            3'd1:    c = CORNER_TWO;
            3'd2:    c = CORNER_FOUR;
            3'd3:    c = CORNER_TWO;
            3'd4:    c = CORNER_THREE;
            default: c = CORNER_FOUR;
        endcase
        return c;
    endfunction

    // Count of zero acts as one, counts above the maximum are capped
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c,
                                                   input int unsigned max_div);
        logic [CNT_W-1:0] n;
        if (c == '0)
            n = CNT_W'(1);
        else if (32'(c) > max_div)
            n = CNT_W'(max_div);
        else
            n = c;
        return n;
    endfunction

endpackage

`default_nettype wire

/* hdl/tqv_ram.sv */
// ----------------------------------------------------------------------------
// tqv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tqv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/tqv_sine_rom.sv */
// ----------------------------------------------------------------------------
// tqv_sine_rom
// Quarter-wave sine ROM, Q1.14 magnitude, registered read with enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tqv_sine_rom
    import tqv_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [$clog2(SINE_TABLE_DEPTH):0]   addr,
    output logic      [ROM_W-1:0]                    data
);

    localparam int DEPTH = SINE_TABLE_DEPTH + 1;

    typedef logic [ROM_W-1:0] rom_t [DEPTH];

    // Shift right, rounding toward zero
    function automatic longint trunc_shr(input longint v, input int s);
        return (v < 0) ? -((-v) >>> s) : (v >>> s);
    endfunction

    // Quotient rounded toward zero, positive divisor, |a| below 2^48
    function automatic longint trunc_div(input longint a, input longint b);
        longint mag;
        longint quo;
        longint rem;
        mag = (a < 0) ? -a : a;
        quo = 0;
        rem = 0;
        for (int i = 47; i >= 0; i--)
        begin
            rem = (rem <<< 1) | ((mag >>> i) & 64'sd1);
            if (rem >= b)
            begin
                rem = rem - b;
                quo = quo | (64'sd1 <<< i);
            end
        end
        return (a < 0) ? -quo : quo;
    endfunction

    // Q30 Taylor series, thirteen terms, rounded to Q1.14
    function automatic rom_t build_rom();
        rom_t   t;
        longint x;
        longint term;
        longint sum;
        for (int i = 0; i < DEPTH; i++)
        begin
            x    = trunc_div(HALF_PI_Q30 * longint'(i), longint'(SINE_TABLE_DEPTH));
            term = x;
            sum  = x;
            for (int n = 1; n <= 12; n++)
            begin
                term = trunc_shr(term * x, 30);
                term = trunc_shr(term * x, 30);
                term = trunc_div(-term, longint'((2 * n) * (2 * n + 1)));
                sum  = sum + term;
            end
            if (sum < 0)
                sum = 0;
            if (sum > (64'sd1 <<< 30))
                sum = 64'sd1 <<< 30;
            t[i] = ROM_W'((sum + 64'sd32768) >>> 16);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [ROM_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* hdl/tqv_axis_tbl.sv */
// ----------------------------------------------------------------------------
// tqv_axis_tbl
// Per-axis table of phase index and texture fraction for k = 0..n.
// Filled after reset and after each count write: a serial divide of the
// per-step increments by 2n, then one entry a cycle by exact accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module tqv_axis_tbl
    import tqv_pkg::*;
#(
    parameter int MAX_DIVISIONS    = MAX_DIVISIONS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic [CNT_W-1:0]                       count,
    input  wire logic                                   rd_en,
    input  wire logic [$clog2(MAX_DIVISIONS+1)-1:0]     rd_addr,
    output logic                                        busy,
    output logic      [CNT_W-1:0]                       n_eff,
    output logic      [$clog2(SINE_TABLE_DEPTH)+1:0]    rd_phase,
    output logic      [TEX_W-1:0]                       rd_frac
);

    localparam int AW = $clog2(MAX_DIVISIONS + 1);
    localparam int SL = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = SL + 2;
    localparam int DW = CNT_W + 1;
    localparam int NW = (SL + 4 > TEX_W + 1) ? SL + 4 : TEX_W + 1;
    localparam int BW = $clog2(NW);

    // Numerator steps: 8 * depth for the phase, 2 * 65536 for the fraction
    localparam logic [NW-1:0] PSTEP = NW'(1) << (SL + 3);
    localparam logic [NW-1:0] FSTEP = NW'(1) << TEX_W;

    fill_state_t state_reg, state_next;

    logic [BW-1:0]    bit_reg, bit_next;
    logic [DW-1:0]    prem_reg, prem_next;
    logic [DW-1:0]    frem_reg, frem_next;
    logic [NW-1:0]    pq_reg, pq_next;
    logic [NW-1:0]    fq_reg, fq_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [PW-1:0]    pacc_reg, pacc_next;
    logic [DW-1:0]    prr_reg, prr_next;
    logic [TEX_W-1:0] facc_reg, facc_next;
    logic [DW-1:0]    frr_reg, frr_next;

    logic [DW-1:0]    two_n;
    logic [DW:0]      ptry, ftry, psum, fsum;
    logic             pbit, fbit, pwrap, fwrap;
    logic             we;

    assign n_eff = eff_count(count, MAX_DIVISIONS);
    assign two_n = {n_eff, 1'b0};

    always_comb
    begin
        ptry  = {prem_reg, PSTEP[bit_reg]};
        ftry  = {frem_reg, FSTEP[bit_reg]};
        pbit  = ptry >= {1'b0, two_n};
        fbit  = ftry >= {1'b0, two_n};
        psum  = {1'b0, prr_reg} + {1'b0, prem_reg};
        fsum  = {1'b0, frr_reg} + {1'b0, frem_reg};
        pwrap = psum >= {1'b0, two_n};
        fwrap = fsum >= {1'b0, two_n};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FILL_DIV;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        prem_next  = prem_reg;
        frem_next  = frem_reg;
        pq_next    = pq_reg;
        fq_next    = fq_reg;
        k_next     = k_reg;
        pacc_next  = pacc_reg;
        prr_next   = prr_reg;
        facc_next  = facc_reg;
        frr_next   = frr_reg;
        we         = 1'b0;
        case (state_reg)
            FILL_DIV:
            begin
                prem_next = pbit ? DW'(ptry - {1'b0, two_n}) : DW'(ptry);
                frem_next = fbit ? DW'(ftry - {1'b0, two_n}) : DW'(ftry);
                pq_next   = {pq_reg[NW-2:0], pbit};
                fq_next   = {fq_reg[NW-2:0], fbit};
                bit_next  = bit_reg - BW'(1);
                if (bit_reg == '0)
                begin
                    state_next = FILL_WALK;
                    k_next     = '0;
                    pacc_next  = '0;
                    facc_next  = '0;
                    prr_next   = DW'(n_eff);   // k = 0: numerator n over 2n
                    frr_next   = DW'(n_eff);
                end
            end
            FILL_WALK:
            begin
                we        = 1'b1;
                k_next    = k_reg + CNT_W'(1);
                prr_next  = pwrap ? DW'(psum - {1'b0, two_n}) : DW'(psum);
                frr_next  = fwrap ? DW'(fsum - {1'b0, two_n}) : DW'(fsum);
                pacc_next = pacc_reg + PW'(pq_reg) + PW'(pwrap);
                facc_next = facc_reg + TEX_W'(fq_reg) + TEX_W'(fwrap);
                if (k_reg == n_eff)
                    state_next = FILL_IDLE;
            end
            default:
            begin
                state_next = FILL_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = FILL_DIV;
            bit_next   = BW'(NW - 1);
            prem_next  = '0;
            frem_next  = '0;
            pq_next    = '0;
            fq_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= BW'(NW - 1);
            prem_reg <= '0;
            frem_reg <= '0;
            pq_reg   <= '0;
            fq_reg   <= '0;
            k_reg    <= '0;
            pacc_reg <= '0;
            prr_reg  <= '0;
            facc_reg <= '0;
            frr_reg  <= '0;
        end
        else
        begin
            bit_reg  <= bit_next;
            prem_reg <= prem_next;
            frem_reg <= frem_next;
            pq_reg   <= pq_next;
            fq_reg   <= fq_next;
            k_reg    <= k_next;
            pacc_reg <= pacc_next;
            prr_reg  <= prr_next;
            facc_reg <= facc_next;
            frr_reg  <= frr_next;
        end
    end

    assign busy = (state_reg != FILL_IDLE);

    tqv_ram #(
        .WIDTH (PW + TEX_W),
        .DEPTH (MAX_DIVISIONS + 1)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(k_reg)),
        .wdata ({pacc_reg, facc_reg}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata ({rd_phase, rd_frac})
    );

endmodule

`default_nettype wire

/* hdl/tqv_vertex_pipe.sv */
// ----------------------------------------------------------------------------
// tqv_vertex_pipe
// Vertex arithmetic: sine lookup, Q1.14 products, ring offset, final scale.
// Whole pipe advances together; the last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tqv_vertex_pipe
    import tqv_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 issue_valid,
    input  wire vtag_t                                issue_tag,
    input  wire logic [$clog2(SINE_TABLE_DEPTH)+1:0]  phase_u,
    input  wire logic [TEX_W-1:0]                     frac_u,
    input  wire logic [$clog2(SINE_TABLE_DEPTH)+1:0]  phase_v,
    input  wire logic [TEX_W-1:0]                     frac_v,
    input  wire logic [RADIUS_W-1:0]                  tube_radius,
    input  wire logic [RADIUS_W-1:0]                  ring_radius,
    output logic                                      adv,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output vertex_t                                   out_data
);

    localparam int SL = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = SL + 2;

    function automatic logic [SL:0] rom_addr(input logic [1:0] q, input logic [SL-1:0] r);
        return q[0] ? ((SL+1)'(SINE_TABLE_DEPTH) - {1'b0, r}) : {1'b0, r};
    endfunction

    function automatic logic signed [NORM_W-1:0] signed_of(input logic neg,
                                                            input logic [ROM_W-1:0] m);
        logic signed [NORM_W-1:0] v;
        v = $signed({1'b0, m});
        return neg ? -v : v;
    endfunction

    // stage 1: table data arriving from the RAMs
    logic  v1_reg;
    vtag_t tag1_reg;

    logic [1:0]    pu_q, pu_cq, pv_q, pv_cq;
    logic [SL-1:0] pu_r, pv_r;

    assign pu_q  = phase_u[PW-1 -: 2];
    assign pu_cq = pu_q + 2'd1;
    assign pu_r  = phase_u[SL-1:0];
    assign pv_q  = phase_v[PW-1 -: 2];
    assign pv_cq = pv_q + 2'd1;
    assign pv_r  = phase_v[SL-1:0];

    // stage 2: sine magnitudes
    logic             v2_reg;
    vtag_t            tag2_reg;
    logic             su_neg_reg, cu_neg_reg, sv_neg_reg, cv_neg_reg;
    logic [TEX_W-1:0] fu2_reg, fv2_reg;
    logic [ROM_W-1:0] su_m, cu_m, sv_m, cv_m;

    tqv_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_su (
        .clk(clk), .en(adv), .addr(rom_addr(pu_q, pu_r)), .data(su_m));
    tqv_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_cu (
        .clk(clk), .en(adv), .addr(rom_addr(pu_cq, pu_r)), .data(cu_m));
    tqv_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_sv (
        .clk(clk), .en(adv), .addr(rom_addr(pv_q, pv_r)), .data(sv_m));
    tqv_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_cv (
        .clk(clk), .en(adv), .addr(rom_addr(pv_cq, pv_r)), .data(cv_m));

    logic signed [NORM_W-1:0]          sp, cp, st, ct;
    logic signed [RADIUS_W:0]          tube_s;
    logic signed [RADIUS_W+NORM_W:0]   trcp_full, trsp_full;
    logic signed [2*NORM_W-1:0]        nx_full, nz_full;

    always_comb
    begin
        sp        = signed_of(su_neg_reg, su_m);
        cp        = signed_of(cu_neg_reg, cu_m);
        st        = signed_of(sv_neg_reg, sv_m);
        ct        = signed_of(cv_neg_reg, cv_m);
        tube_s    = $signed({1'b0, tube_radius});
        trcp_full = (tube_s * cp + (RADIUS_W+NORM_W+1)'(8192)) >>> 14;
        trsp_full = (tube_s * sp + (RADIUS_W+NORM_W+1)'(8192)) >>> 14;
        nx_full   = (cp * ct + (2*NORM_W)'(8192)) >>> 14;
        nz_full   = (cp * st + (2*NORM_W)'(8192)) >>> 14;
    end

    // stage 3: products
    logic                     v3_reg;
    vtag_t                    tag3_reg;
    logic signed [TR_W-1:0]   trcp3_reg, trsp3_reg;
    logic signed [NORM_W-1:0] nx3_reg, ny3_reg, nz3_reg, ct3_reg, st3_reg;
    logic [TEX_W-1:0]         fu3_reg, fv3_reg;

    logic signed [W_W-1:0] w;

    assign w = $signed({3'b000, ring_radius}) + $signed({trcp3_reg[TR_W-1], trcp3_reg});

    // stage 4: ring offset added
    logic                     v4_reg;
    vtag_t                    tag4_reg;
    logic signed [W_W-1:0]    w4_reg;
    logic signed [TR_W-1:0]   y4_reg;
    logic signed [NORM_W-1:0] nx4_reg, ny4_reg, nz4_reg, ct4_reg, st4_reg;
    logic [TEX_W-1:0]         fu4_reg, fv4_reg;

    logic signed [W_W+NORM_W-1:0] x_full, z_full;

    always_comb
    begin
        x_full = (w4_reg * ct4_reg + (W_W+NORM_W)'(8192)) >>> 14;
        z_full = (w4_reg * st4_reg + (W_W+NORM_W)'(8192)) >>> 14;
    end

    // stage 5: output register
    logic    out_valid_reg;
    vertex_t out_data_reg;

    assign adv = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= issue_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag1_reg   <= issue_tag;

            tag2_reg   <= tag1_reg;
            su_neg_reg <= pu_q[1];
            cu_neg_reg <= pu_cq[1];
            sv_neg_reg <= pv_q[1];
            cv_neg_reg <= pv_cq[1];
            fu2_reg    <= frac_u;
            fv2_reg    <= frac_v;

            tag3_reg   <= tag2_reg;
            trcp3_reg  <= trcp_full[TR_W-1:0];
            trsp3_reg  <= trsp_full[TR_W-1:0];
            nx3_reg    <= nx_full[NORM_W-1:0];
            nz3_reg    <= nz_full[NORM_W-1:0];
            ny3_reg    <= sp;
            ct3_reg    <= ct;
            st3_reg    <= st;
            fu3_reg    <= fu2_reg;
            fv3_reg    <= fv2_reg;

            tag4_reg   <= tag3_reg;
            w4_reg     <= w;
            y4_reg     <= trsp3_reg;
            nx4_reg    <= nx3_reg;
            ny4_reg    <= ny3_reg;
            nz4_reg    <= nz3_reg;
            ct4_reg    <= ct3_reg;
            st4_reg    <= st3_reg;
            fu4_reg    <= fu3_reg;
            fv4_reg    <= fv3_reg;

            out_data_reg.corner <= tag4_reg.corner;
            out_data_reg.pos_x  <= x_full[POS_W-1:0];
            out_data_reg.pos_y  <= {{(POS_W-TR_W){y4_reg[TR_W-1]}}, y4_reg};
            out_data_reg.pos_z  <= z_full[POS_W-1:0];
            out_data_reg.norm_x <= nx4_reg;
            out_data_reg.norm_y <= ny4_reg;
            out_data_reg.norm_z <= nz4_reg;
            out_data_reg.tex_u  <= fu4_reg;
            out_data_reg.tex_v  <= fv4_reg;
            out_data_reg.last   <= tag4_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* hdl/torus_quad_vertex_generator.sv */
// ----------------------------------------------------------------------------
// torus_quad_vertex_generator
// Emits the six vertices of one torus quad per request.
//
// Use:
//   in_*   : one request per quad (stack_index, slice_index), valid/ready.
//            Indices beyond the configured counts are clamped to count-1.
//   out_*  : six vertices per quad, corners 1,2,4,2,3,4; the sixth
//            carries last. Position Q12.12, normal Q1.14, texture Q1.16.
//   cfg_*  : plain write port, one register per index, no read-back.
//            Write only while no quad is in flight.
// Throughput: one vertex per cycle while the receiver does not stall; the
//   corner sequencer feeding the five-stage vertex pipe sets this rate.
//   A new quad is taken in the cycle its predecessor issues its sixth vertex.
// An accepted quad is held in the corner sequencer, then its first vertex runs the pipe.
// Reset, and each write of slice_count or stack_count, rebuilds the phase
//   and fraction tables, in_ready held low.
// Receiver stall: the whole pipe holds; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module torus_quad_vertex_generator
    import tqv_pkg::*;
#(
    parameter int MAX_DIVISIONS    = MAX_DIVISIONS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire quad_t                 in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output vertex_t                    out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_DIVISIONS + 1);
    localparam int PW = $clog2(SINE_TABLE_DEPTH) + 2;

    // configuration registers
    logic [RADIUS_W-1:0] tube_reg, ring_reg;
    logic [CNT_W-1:0]    slice_cnt_reg, stack_cnt_reg;
    logic                start_u_reg, start_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tube_reg      <= TUBE_RESET;
            ring_reg      <= RING_RESET;
            slice_cnt_reg <= COUNT_RESET;
            stack_cnt_reg <= COUNT_RESET;
            start_u_reg   <= 1'b0;
            start_v_reg   <= 1'b0;
        end
        else
        begin
            start_u_reg <= cfg_we && (cfg_index == REG_SLICE_COUNT);
            start_v_reg <= cfg_we && (cfg_index == REG_STACK_COUNT);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TUBE_RADIUS: tube_reg      <= cfg_data[RADIUS_W-1:0];
                    REG_RING_RADIUS: ring_reg      <= cfg_data[RADIUS_W-1:0];
                    REG_SLICE_COUNT: slice_cnt_reg <= cfg_data[CNT_W-1:0];
                    REG_STACK_COUNT: stack_cnt_reg <= cfg_data[CNT_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // corner sequencer: holds the clamped quad and steps through six corners
    logic             hold_reg;
    logic [CNT_W-1:0] sl_reg, st_reg;
    logic [2:0]       step_reg;

    logic             adv, busy, busy_u, busy_v, accept, issue;
    logic [CNT_W-1:0] n_u, n_v, sl_in, st_in, csl, cst;
    corner_t          corner;
    vtag_t            tag;

    logic [PW-1:0]    phase_u, phase_v;
    logic [TEX_W-1:0] frac_u, frac_v;

    // a pending rebuild start counts as busy, so no request slips in first
    assign busy     = busy_u || busy_v || start_u_reg || start_v_reg;
    assign issue    = hold_reg && adv;
    assign in_ready = !busy && (!hold_reg || (adv && step_reg == SEQ_LAST));
    assign accept   = in_valid && in_ready;

    assign sl_in = ({1'b0, in_data.slice_index} > n_u - CNT_W'(1)) ?
                   n_u - CNT_W'(1) : {1'b0, in_data.slice_index};
    assign st_in = ({1'b0, in_data.stack_index} > n_v - CNT_W'(1)) ?
                   n_v - CNT_W'(1) : {1'b0, in_data.stack_index};

    always_comb
    begin
        corner     = corner_at(step_reg);
        csl        = sl_reg + CNT_W'((corner == CORNER_TWO) || (corner == CORNER_THREE));
        cst        = st_reg + CNT_W'((corner == CORNER_THREE) || (corner == CORNER_FOUR));
        tag.corner = corner;
        tag.last   = (step_reg == SEQ_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (issue)
            begin
                if (step_reg == SEQ_LAST)
                begin
                    step_reg <= '0;
                    hold_reg <= accept;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
            else if (accept)
            begin
                hold_reg <= 1'b1;
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sl_reg <= sl_in;
            st_reg <= st_in;
        end
    end

    // slice axis (phi, tex_u) and stack axis (theta, tex_v) tables
    tqv_axis_tbl #(
        .MAX_DIVISIONS    (MAX_DIVISIONS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_tbl_u (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_u_reg),
        .count    (slice_cnt_reg),
        .rd_en    (adv),
        .rd_addr  (AW'(csl)),
        .busy     (busy_u),
        .n_eff    (n_u),
        .rd_phase (phase_u),
        .rd_frac  (frac_u)
    );

    tqv_axis_tbl #(
        .MAX_DIVISIONS    (MAX_DIVISIONS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_tbl_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_v_reg),
        .count    (stack_cnt_reg),
        .rd_en    (adv),
        .rd_addr  (AW'(cst)),
        .busy     (busy_v),
        .n_eff    (n_v),
        .rd_phase (phase_v),
        .rd_frac  (frac_v)
    );

    tqv_vertex_pipe #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (hold_reg),
        .issue_tag   (tag),
        .phase_u     (phase_u),
        .frac_u      (frac_u),
        .phase_v     (phase_v),
        .frac_v      (frac_v),
        .tube_radius (tube_reg),
        .ring_radius (ring_reg),
        .adv         (adv),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // table rebuild must shut the input off
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("request taken during table rebuild");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.corner == CORNER_FOUR)
        else $error("last vertex not on corner four");

    a_count_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == REG_SLICE_COUNT || cfg_index == REG_STACK_COUNT)
        |=> ##1 busy)
        else $error("count write did not start a rebuild");

    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> hold_reg && step_reg == '0)
        else $error("accepted quad not loaded at first corner");

endmodule

`default_nettype wire
